[sv/ira_pkg.sv]
// shared types and constants for the interval row assigner
package ira_pkg;

  localparam int PosW        = 31;
  localparam int PadW        = 8;
  localparam int RelW        = 32;
  localparam int RowOutW     = 6;
  localparam logic [PadW-1:0] GapPadReset = 8'd5;

  typedef struct packed {
    logic [PosW-1:0] start_position;
    logic [PosW-1:0] end_position;
    logic            first_of_list;
  } ira_in_t;

  typedef struct packed {
    logic [RowOutW-1:0] row_index;
    logic               rows_full;
  } ira_out_t;

  // control part of a request moving down the cell chain
  typedef struct packed {
    logic valid;
    logic first;
    logic placed;
  } tok_ctrl_t;

endpackage

[sv/ira_cell.sv]
// one row cell: holds a row's state and passes the request to the next cell
module ira_cell #(
  parameter int IdxW    = 6,
  parameter int CellIdx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  ira_pkg::tok_ctrl_t        ctrl_i,
  input  logic [ira_pkg::PosW-1:0]  start_i,
  input  logic [ira_pkg::RelW-1:0]  rel_i,
  input  logic [IdxW-1:0]           row_i,
  output ira_pkg::tok_ctrl_t        ctrl_o,
  output logic [ira_pkg::PosW-1:0]  start_o,
  output logic [ira_pkg::RelW-1:0]  rel_o,
  output logic [IdxW-1:0]           row_o
);
  import ira_pkg::*;

  logic            used_q, used_d;
  logic            used_eff, free, take;
  logic [RelW-1:0] release_q;
  tok_ctrl_t       ctrl_q;
  logic [PosW-1:0] start_q;
  logic [RelW-1:0] rel_q;
  logic [IdxW-1:0] row_q;

  always_comb begin
    // a first-of-list request wipes the row as it passes
    used_eff = ctrl_i.first ? 1'b0 : used_q;
    free     = !used_eff || (release_q < {1'b0, start_i});
    take     = ctrl_i.valid && !ctrl_i.placed && free;
    used_d   = used_q;
    if (adv_i && ctrl_i.valid) begin
      used_d = used_eff | take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      ctrl_q <= '0;
    end else begin
      used_q <= used_d;
      if (adv_i) begin
        ctrl_q <= '{valid: ctrl_i.valid, first: ctrl_i.first,
                    placed: ctrl_i.placed | take};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      start_q <= start_i;
      rel_q   <= rel_i;
      row_q   <= take ? IdxW'(CellIdx) : row_i;
    end
    if (adv_i && take) begin
      release_q <= rel_i;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign start_o = start_q;
  assign rel_o   = rel_q;
  assign row_o   = row_q;

endmodule

[sv/interval_row_assigner.sv]
// interval row assigner: a chain of MAX_ROWS row cells, one request per cell per cycle
// a request passes through the MAX_ROWS cell registers and then the output register; a stall holds it in place
// throughput: one request per cycle; each request walks the cell chain one row per cycle,
//   so up to MAX_ROWS + 1 requests are in flight, and the whole chain stalls on output backpressure
// reset: asynchronous, active low; clears all row-used bits and in-flight requests,
//   sets gap_pad to 5; no clearing pass, the block takes requests right after reset
module interval_row_assigner #(
  parameter int MAX_ROWS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ira_pkg::PadW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ira_pkg::ira_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ira_pkg::ira_out_t            out_data_o
);
  import ira_pkg::*;

  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IdxW = (RowW > RowOutW) ? RowW : RowOutW;

  logic [PadW-1:0] pad_q;
  logic            out_valid_q;
  ira_out_t        out_q;
  logic            adv;

  tok_ctrl_t       ctrl  [MAX_ROWS+1];
  logic [PosW-1:0] start [MAX_ROWS+1];
  logic [RelW-1:0] rel   [MAX_ROWS+1];
  logic [IdxW-1:0] row   [MAX_ROWS+1];

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ctrl[0]  = '{valid: in_valid_i, first: in_data_i.first_of_list, placed: 1'b0};
    start[0] = in_data_i.start_position;
    rel[0]   = RelW'(in_data_i.end_position) + RelW'(pad_q);
    row[0]   = '0;
  end

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    ira_cell #(
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .ctrl_i  (ctrl[g]),
      .start_i (start[g]),
      .rel_i   (rel[g]),
      .row_i   (row[g]),
      .ctrl_o  (ctrl[g+1]),
      .start_o (start[g+1]),
      .rel_o   (rel[g+1]),
      .row_o   (row[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q       <= GapPadReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pad_q <= cfg_data_i;
      end
      if (adv) begin
        out_valid_q <= ctrl[MAX_ROWS].valid;
      end
    end
  end

  // a request that passed every cell unplaced found no free row
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.row_index <= ctrl[MAX_ROWS].placed ? row[MAX_ROWS][RowOutW-1:0] : '0;
      out_q.rows_full <= !ctrl[MAX_ROWS].placed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/ira_checker.sv]
// port-level checks for the interval row assigner, bound to the top level
module ira_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [ira_pkg::PadW-1:0]  cfg_data_i,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input ira_pkg::ira_in_t          in_data_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input ira_pkg::ira_out_t         out_data_o
);
  import ira_pkg::*;

  // a result waiting to be taken holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // overflow always reports row zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rows_full |-> out_data_o.row_index == '0)
    else $error("overflow with nonzero row");

  // input only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a held result freezes the whole chain, input included
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while result held");

endmodule

bind interval_row_assigner ira_checker u_ira_checker (.*);

[dv/row_assign_monitor.sv]
// channel monitor for the interval row assigner: predicts each placement and compares
module row_assign_monitor #(
  parameter int NumRows = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [ira_pkg::PadW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  ira_pkg::ira_in_t         in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  ira_pkg::ira_out_t        out_data_i,
  output int                       mismatch_cnt_o,
  output int                       pending_o,
  output int                       placed_cnt_o,
  output int                       full_cnt_o
);
  import ira_pkg::*;

  // local copy of the row table
  logic [NumRows-1:0] row_taken;
  logic [32:0]        row_free_after [NumRows];
  logic [PadW-1:0]    pad;

  ira_out_t expected_rows [$];
  ira_out_t want;
  int       mismatches;
  int       placed;
  int       overflows;

  // lowest row that is unused or released strictly before the start
  function automatic ira_out_t place_interval(ira_in_t req);
    ira_out_t res;
    int       slot;
    slot = -1;
    if (req.first_of_list) row_taken = '0;
    for (int r = 0; r < NumRows; r++) begin
      if (slot < 0 && (!row_taken[r] || row_free_after[r] < {2'b00, req.start_position}))
        slot = r;
    end
    if (slot < 0) begin
      res.row_index = '0;
      res.rows_full = 1'b1;
    end else begin
      row_taken[slot]      = 1'b1;
      row_free_after[slot] = {2'b00, req.end_position} + {25'd0, pad};
      res.row_index        = slot[RowOutW-1:0];
      res.rows_full        = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_taken = '0;
      foreach (row_free_after[r]) row_free_after[r] = '0;
      pad = GapPadReset;
      expected_rows.delete();
      mismatches = 0;
      placed     = 0;
      overflows  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: result with no request pending: row %0d full %0b", $time,
                   out_data_i.row_index, out_data_i.rows_full);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          if (out_data_i.row_index !== want.row_index) begin
            $display("%0t: row_index expected %0d actual %0d", $time,
                     want.row_index, out_data_i.row_index);
            mismatches++;
          end
          if (out_data_i.rows_full !== want.rows_full) begin
            $display("%0t: rows_full expected %0b actual %0b", $time,
                     want.rows_full, out_data_i.rows_full);
            mismatches++;
          end
          placed++;
          if (want.rows_full) overflows++;
        end
      end
      if (in_valid_i && in_ready_i) expected_rows = {expected_rows, place_interval(in_data_i)};
      if (cfg_valid_i && cfg_ready_i) pad = cfg_data_i;
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= expected_rows.size();
    placed_cnt_o   <= placed;
    full_cnt_o     <= overflows;
  end

endmodule

[dv/interval_row_assigner_tb.sv]
// testbench top for the interval row assigner: clock, reset, stimulus and verdict
module interval_row_assigner_tb;
  import ira_pkg::*;

  localparam int     NumRows    = 64;
  localparam int     Latency    = NumRows + 1;
  localparam int     CycleLimit = 400000;
  localparam int     HoldCycles = 400;
  localparam int     PhaseItems = 80;
  localparam longint PosMax     = 64'h7FFF_FFFF;

  typedef enum int {ListDense, ListSparse, ListNoise} list_kind_e;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [PadW-1:0] cfg_data  = '0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  ira_in_t         in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ira_out_t        out_data;

  int   mismatch_cnt;
  int   pending;
  int   placed_cnt;
  int   full_cnt;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_tog    = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;
  int   cycles      = 0;

  interval_row_assigner #(
    .MAX_ROWS(NumRows)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  row_assign_monitor #(
    .NumRows(NumRows)
  ) monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending),
    .placed_cnt_o  (placed_cnt),
    .full_cnt_o    (full_cnt)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: no progress after %0d cycles, %0d results outstanding", $time, cycles,
               pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when the toggle flips
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_request(input logic [PosW-1:0] s, input logic [PosW-1:0] e,
                              input logic f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_data.start_position <= s;
    in_data.end_position   <= e;
    in_data.first_of_list  <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  // pending is registered in the monitor, so always step first
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_pad(input logic [PadW-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_list(input list_kind_e kind, inout int left);
    longint cur;
    longint stop;
    int     count;
    int     pick;
    bit     fresh;
    pick = $urandom_range(99);
    if (pick < 50) cur = $urandom_range(1000);
    else if (pick < 80) cur = $urandom_range(32'h7FFF_FFFF);
    else cur = PosMax - $urandom_range(100000);
    // a few sparse lists carry on from the previous row table
    fresh = (kind != ListSparse) || ($urandom_range(9) != 0);
    case (kind)
      ListDense:  count = $urandom_range(100, 66);
      ListSparse: count = $urandom_range(40, 4);
      default:    count = $urandom_range(8, 1);
    endcase
    for (int i = 0; i < count; i++) begin
      case (kind)
        ListDense: begin
          // tightly packed long intervals pile up until every row is busy
          cur  = cur + $urandom_range(2);
          stop = cur + (($urandom_range(99) < 85) ? $urandom_range(5000, 150)
                                                  : $urandom_range(40));
        end
        ListSparse: begin
          cur = cur + $urandom_range(3000);
          if ($urandom_range(19) == 0) stop = cur - longint'($urandom_range(5000));
          else stop = cur + $urandom_range(4000);
        end
        default: begin
          cur  = $urandom & PosMax;
          stop = $urandom & PosMax;
        end
      endcase
      if (cur > PosMax) cur = PosMax;
      if (stop > PosMax) stop = PosMax;
      if (stop < 0) stop = 0;
      if (kind == ListNoise) send_request(cur[PosW-1:0], stop[PosW-1:0], 1'($urandom_range(1)));
      else send_request(cur[PosW-1:0], stop[PosW-1:0], i == 0 && fresh);
      left--;
    end
  endtask

  task automatic run_phase(input logic [PadW-1:0] pad_val, input int tx_pct, input int rx_pct,
                           input bit long_hold);
    int         left;
    int         pick;
    list_kind_e kind;
    write_pad(pad_val);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    if (long_hold) hold_tog <= ~hold_tog;
    left = PhaseItems;
    while (left > 0) begin
      pick = $urandom_range(99);
      kind = (pick < 45) ? ListDense : (pick < 80) ? ListSparse : ListNoise;
      send_list(kind, left);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset pad of 5; first request lands on never-used rows
    send_request(31'd0, 31'd0, 1'b0);
    send_request(31'd0, 31'd0, 1'b0);
    send_request(31'd5, 31'd7, 1'b0);
    send_request(31'd6, 31'd100, 1'b0);
    send_request(31'd6, 31'd2, 1'b0);            // end below start
    send_request(31'd3, 31'd3, 1'b0);            // start goes backward
    send_request('1, '1, 1'b1);
    send_request('1, 31'd0, 1'b0);
    send_request('1, '1, 1'b0);
    send_request(31'h2AAA_AAAA, 31'h5555_5555, 1'b1);
    send_request(31'h5555_5555, 31'h2AAA_AAAA, 1'b0);

    write_pad(8'd255);
    send_request(31'd0, '1, 1'b1);
    send_request('1, '1, 1'b0);
    send_request(31'd300, 31'd44, 1'b0);
    send_request(31'd299, 31'd1, 1'b0);
    send_request(31'd300, 31'd300, 1'b0);

    // zero pad: a row frees one position after its end
    write_pad(8'd0);
    send_request(31'd10, 31'd20, 1'b1);
    send_request(31'd20, 31'd20, 1'b0);
    send_request(31'd21, 31'd21, 1'b0);

    run_phase(PadW'($urandom_range(255)), 12, 46, 1'b0);
    run_phase(8'd0, 12, 46, 1'b0);
    run_phase(8'd255, 46, 12, 1'b0);
    run_phase(PadW'($urandom_range(255)), 46, 12, 1'b0);
    run_phase(GapPadReset, 0, 0, 1'b1);
    run_phase(PadW'($urandom_range(255)), 0, 0, 1'b0);

    in_valid <= 1'b0;
    wait_drained();
    repeat (2 * Latency) @(posedge clk);
    $display("placed %0d intervals, %0d of them with all rows busy, pads from 0 to 255",
             placed_cnt, full_cnt);
    $display("both sides idled in both ratios, output held off for %0d cycles once",
             HoldCycles);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
